FILE: sv/round_robin_thread_scheduler_core_assert.svh
// ----------------------------------------------------------------------------
// Scheduler assertion macros
// Concurrent assertion shorthands, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_CORE_ASSERT_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_CORE_ASSERT_SVH

// expression holds at every edge out of reset
`define RRTS_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// consequent holds in the same cycle as the antecedent
`define RRTS_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: sv/rrts_pkg.sv
// ----------------------------------------------------------------------------
// Scheduler package
// Field widths, command and status codes, slot entry layout.
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int CMD_W      = 3;
  localparam int KIND_W     = 2;
  localparam int ID_W       = 16;
  localparam int TICK_W     = 32;
  localparam int TIME_W     = 64;
  localparam int BTN_W      = 32;
  localparam int STATUS_W   = 3;
  localparam int SLOT_OUT_W = 4;
  localparam int NUM_KINDS  = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_CREATE   = 3'd0,
    CMD_REGISTER = 3'd1,
    CMD_YIELD    = 3'd2,
    CMD_JOIN     = 3'd3,
    CMD_WAIT     = 3'd4,
    CMD_FINISH   = 3'd5,
    CMD_KILL     = 3'd6,
    CMD_BUTTON   = 3'd7
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_CHOSEN   = 3'd0,
    ST_DISPATCH = 3'd1,
    ST_NONE     = 3'd2,
    ST_FULL     = 3'd3,
    ST_DONE     = 3'd4
  } status_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLICKED  = 2'd0,
    KIND_RELEASED = 2'd1,
    KIND_CHANGED  = 2'd2,
    KIND_CMD      = 2'd3
  } kind_t;

  // one slot of the thread table as stored in memory
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic              dep_v;
    logic [ID_W-1:0]   dep_id;
    logic              waiting;
    logic              is_hnd;
    logic [TIME_W-1:0] resume;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // button event check result
  typedef struct packed {
    logic             hit;
    kind_t            kind;
    logic [BTN_W-1:0] value;
  } evt_res_t;

endpackage

FILE: sv/rrts_if.sv
// ----------------------------------------------------------------------------
// Scheduler channel interfaces
// Valid/ready command channel and result channel.
// ----------------------------------------------------------------------------
interface rrts_in_if import rrts_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [KIND_W-1:0] handler_kind;
  logic [ID_W-1:0]   target_id;
  logic [TICK_W-1:0] wait_ticks;
  logic [TIME_W-1:0] now;
  logic [BTN_W-1:0]  buttons_new;
  logic [BTN_W-1:0]  buttons_old;

  modport source (
    output valid, command, handler_kind, target_id, wait_ticks, now,
           buttons_new, buttons_old,
    input  ready
  );
  modport sink (
    input  valid, command, handler_kind, target_id, wait_ticks, now,
           buttons_new, buttons_old,
    output ready
  );
endinterface

interface rrts_out_if import rrts_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [SLOT_OUT_W-1:0] slot;
  logic [ID_W-1:0]       run_id;
  logic [KIND_W-1:0]     event_kind;
  logic [BTN_W-1:0]      event_value;

  modport source (
    output valid, status, slot, run_id, event_kind, event_value,
    input  ready
  );
  modport sink (
    input  valid, status, slot, run_id, event_kind, event_value,
    output ready
  );
endinterface

FILE: sv/rrts_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module rrts_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/rrts_evt.sv
// ----------------------------------------------------------------------------
// Button event rotation
// Holds the rotating event phase and picks the handler to dispatch.
// ----------------------------------------------------------------------------
module rrts_evt import rrts_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [2:0]       present,
  input  logic [BTN_W-1:0] buttons_new,
  input  logic [BTN_W-1:0] buttons_old,
  output evt_res_t         res
);

  kind_t            phase_r;
  kind_t            phase_nxt;
  logic [BTN_W-1:0] diff;
  logic [BTN_W-1:0] pressed;
  logic [BTN_W-1:0] released;
  logic             hit_click;
  logic             hit_rel;
  logic             hit_chg;

  // edge masks of the button word
  assign diff     = buttons_new ^ buttons_old;
  assign pressed  = diff & buttons_new;
  assign released = diff & buttons_old;

  // a miss falls through to the later phases in the same step
  assign hit_click = (phase_r == KIND_CLICKED) && present[0] && (pressed != '0);
  assign hit_rel   = (phase_r inside {KIND_CLICKED, KIND_RELEASED}) && !hit_click &&
                     present[1] && (released != '0);
  assign hit_chg   = (phase_r inside {KIND_CLICKED, KIND_RELEASED, KIND_CHANGED}) &&
                     !hit_click && !hit_rel && present[2] && (diff != '0);

  always_comb begin
    res       = '0;
    phase_nxt = KIND_CLICKED;
    if (hit_click) begin
      res.hit   = 1'b1;
      res.kind  = KIND_CLICKED;
      res.value = pressed;
      phase_nxt = KIND_RELEASED;
    end else if (hit_rel) begin
      res.hit   = 1'b1;
      res.kind  = KIND_RELEASED;
      res.value = released;
      phase_nxt = KIND_CHANGED;
    end else if (hit_chg) begin
      res.hit   = 1'b1;
      res.kind  = KIND_CHANGED;
      res.value = buttons_new;
    end
  end

  // phase advances once per schedule step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= KIND_CLICKED;
    end else if (step) begin
      phase_r <= phase_nxt;
    end
  end

endmodule

FILE: sv/round_robin_thread_scheduler_core.sv
// ----------------------------------------------------------------------------
// Round-robin thread scheduler core
// Thread table in a RAM, walked one slot per cycle for scans and sweeps.
// ----------------------------------------------------------------------------
//   channel  dir  handshake        payload
//   in_ch    in   valid / ready    command, kind, target, ticks, now, buttons
//   out_ch   out  valid / ready    status, slot, run_id, event kind/value
//
// Create and register go through S_CMD and S_OUT to the output register;
// a schedule step runs S_SCHED, then S_IDREAD on a dispatch or S_SCAN on a scan.
// Join, wait and handler finish add S_RMW first, kill adds an S_SWEEP over every
// slot, thread finish adds S_RMW and S_SWEEP; the RAM read port walks each slot.
// Synchronous reset; valid bits stand in for the table's reset, no clear pass.
// A new command is taken while a finished result waits in the output register.
// ----------------------------------------------------------------------------
`include "round_robin_thread_scheduler_core_assert.svh"

module round_robin_thread_scheduler_core import rrts_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  rrts_in_if.sink    in_ch,
  rrts_out_if.source out_ch
);

  localparam int SW = $clog2(SLOTS);
  localparam int RW = $clog2(SLOTS + 1);
  localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);
  localparam logic [RW-1:0] NONE = RW'(SLOTS);

  typedef enum logic [2:0] {
    S_IDLE, S_CMD, S_RMW, S_SWEEP, S_SCHED, S_SCAN, S_IDREAD, S_OUT
  } state_t;

  state_t            state_r;
  cmd_t              cmd_r;
  kind_t             kind_r;
  logic [ID_W-1:0]   target_r;
  logic [TIME_W-1:0] now_r;
  logic [TIME_W-1:0] resume_r;
  logic [BTN_W-1:0]  bn_r;
  logic [BTN_W-1:0]  bo_r;

  logic [RW-1:0]     running_r;
  logic [SW-1:0]     saved_r;
  logic [ID_W-1:0]   next_id_r;
  logic [RW-1:0]     hnd_r [NUM_KINDS];
  logic [SLOTS-1:0]  used_r;
  logic [SLOTS-1:0]  written_r;

  logic [SW-1:0]     cnt_r;
  logic [SW-1:0]     steps_r;
  logic [ID_W-1:0]   sweep_id_r;
  logic              kill_r;
  logic              found_r;

  status_t           res_status_r;
  logic [SW-1:0]     res_slot_r;
  logic [ID_W-1:0]   res_id_r;
  kind_t             res_kind_r;
  logic [BTN_W-1:0]  res_val_r;

  logic                  out_valid_r;
  status_t               out_status_r;
  logic [SLOT_OUT_W-1:0] out_slot_r;
  logic [ID_W-1:0]       out_id_r;
  kind_t                 out_kind_r;
  logic [BTN_W-1:0]      out_val_r;

  logic              run;
  logic [SW-1:0]     run_idx;
  logic [SW-1:0]     scan_start;
  entry_t            ent;
  entry_t            wr_ent;
  logic [ENTRY_W-1:0] rd_data;
  logic              wr_en;
  logic [SW-1:0]     wr_addr;
  logic              rd_en;
  logic [SW-1:0]     rd_addr;
  logic [SLOTS-1:0]  used_tmp;
  logic [SLOTS-1:0]  used_fill;
  logic              free_found;
  logic [SW-1:0]     free_idx;
  logic              scan_ok;
  logic              kill_hit;
  logic              in_xfer;
  logic              out_load;
  evt_res_t          evt;

  function automatic logic present(input logic [RW-1:0] h);
    return h < NONE;
  endfunction

  function automatic logic [SW-1:0] nxt_slot(input logic [SW-1:0] s);
    return (s == LAST) ? '0 : SW'(s + 1'b1);
  endfunction

  assign in_xfer    = in_ch.valid && in_ch.ready;
  assign run        = running_r < NONE;
  assign run_idx    = running_r[SW-1:0];
  assign scan_start = run ? nxt_slot(run_idx) : '0;
  assign out_load   = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  // entry never written reads as its reset value
  assign ent = written_r[cnt_r] ? entry_t'(rd_data) : '0;

  assign scan_ok  = used_r[cnt_r] && !ent.is_hnd && !ent.dep_v &&
                    (!ent.waiting || (ent.resume < now_r));
  assign kill_hit = kill_r && !found_r && used_r[cnt_r] && (ent.id == sweep_id_r);

  // lowest free slot, with a replaced handler slot freed first
  always_comb begin
    used_tmp = used_r;
    if ((cmd_r == CMD_REGISTER) && present(hnd_r[kind_r])) begin
      used_tmp[hnd_r[kind_r][SW-1:0]] = 1'b0;
    end
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used_tmp[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
    used_fill = used_tmp;
    if (free_found) begin
      used_fill[free_idx] = 1'b1;
    end
  end

  // table RAM port control
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt_r;
    wr_ent  = ent;
    rd_en   = 1'b0;
    rd_addr = cnt_r;
    case (state_r)
      S_CMD: begin
        case (cmd_r)
          CMD_CREATE, CMD_REGISTER: begin
            wr_en         = free_found;
            wr_addr       = free_idx;
            wr_ent        = '0;
            wr_ent.id     = next_id_r;
            wr_ent.is_hnd = (cmd_r == CMD_REGISTER);
          end
          CMD_JOIN, CMD_WAIT, CMD_FINISH: begin
            rd_en   = run;
            rd_addr = run_idx;
          end
          CMD_KILL: begin
            rd_en   = 1'b1;
            rd_addr = '0;
          end
          CMD_BUTTON: begin
            if (present(hnd_r[KIND_CMD])) begin
              rd_en   = 1'b1;
              rd_addr = hnd_r[KIND_CMD][SW-1:0];
            end else if (run) begin
              rd_en   = 1'b1;
              rd_addr = run_idx;
            end
          end
          default: ;
        endcase
      end
      S_RMW: begin
        case (cmd_r)
          CMD_JOIN: begin
            wr_en         = 1'b1;
            wr_ent.dep_v  = 1'b1;
            wr_ent.dep_id = target_r;
          end
          CMD_WAIT: begin
            wr_en          = 1'b1;
            wr_ent.waiting = 1'b1;
            wr_ent.resume  = resume_r;
          end
          CMD_FINISH: begin
            rd_en   = !ent.is_hnd;
            rd_addr = '0;
          end
          default: ;
        endcase
      end
      S_SWEEP: begin
        wr_en         = ent.dep_v && (ent.dep_id == sweep_id_r);
        wr_ent.dep_v  = 1'b0;
        wr_ent.dep_id = '0;
        rd_en         = (cnt_r != LAST);
        rd_addr       = SW'(cnt_r + 1'b1);
      end
      S_SCHED: begin
        rd_en   = 1'b1;
        rd_addr = evt.hit ? hnd_r[evt.kind][SW-1:0] : scan_start;
      end
      S_SCAN: begin
        wr_en          = scan_ok;
        wr_ent.waiting = 1'b0;
        rd_en          = !scan_ok && (steps_r != LAST);
        rd_addr        = nxt_slot(cnt_r);
      end
      default: ;
    endcase
  end

  rrts_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_ent),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rrts_evt u_evt (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (state_r == S_SCHED),
    .present     ({present(hnd_r[KIND_CHANGED]), present(hnd_r[KIND_RELEASED]),
                   present(hnd_r[KIND_CLICKED])}),
    .buttons_new (bn_r),
    .buttons_old (bo_r),
    .res         (evt)
  );

  // command sequencer with table flags and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      running_r   <= '0;
      saved_r     <= '0;
      next_id_r   <= '0;
      used_r      <= '0;
      written_r   <= '0;
      kill_r      <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < NUM_KINDS; k++) begin
        hnd_r[k] <= NONE;
      end
    end else begin
      if (out_ch.ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            cmd_r      <= cmd_t'(in_ch.command);
            kind_r     <= kind_t'(in_ch.handler_kind);
            target_r   <= in_ch.target_id;
            now_r      <= in_ch.now;
            resume_r   <= in_ch.now + TIME_W'(in_ch.wait_ticks);
            bn_r       <= in_ch.buttons_new;
            bo_r       <= in_ch.buttons_old;
            res_kind_r <= KIND_CLICKED;
            res_val_r  <= '0;
            state_r    <= S_CMD;
          end
        end
        S_CMD: begin
          case (cmd_r)
            CMD_CREATE, CMD_REGISTER: begin
              used_r <= used_fill;
              if (cmd_r == CMD_REGISTER) begin
                hnd_r[kind_r] <= free_found ? RW'(free_idx) : NONE;
              end
              if (free_found) begin
                written_r[free_idx] <= 1'b1;
                next_id_r           <= next_id_r + 1'b1;
                res_status_r        <= ST_DONE;
                res_slot_r          <= free_idx;
                res_id_r            <= next_id_r;
              end else begin
                res_status_r <= ST_FULL;
                res_slot_r   <= '0;
                res_id_r     <= '0;
              end
              state_r <= S_OUT;
            end
            CMD_JOIN, CMD_WAIT, CMD_FINISH: begin
              cnt_r   <= run_idx;
              state_r <= run ? S_RMW : S_SCHED;
            end
            CMD_KILL: begin
              cnt_r      <= '0;
              sweep_id_r <= target_r;
              kill_r     <= 1'b1;
              found_r    <= 1'b0;
              state_r    <= S_SWEEP;
            end
            CMD_BUTTON: begin
              if (present(hnd_r[KIND_CMD])) begin
                saved_r      <= run ? run_idx : '0;
                running_r    <= hnd_r[KIND_CMD];
                cnt_r        <= hnd_r[KIND_CMD][SW-1:0];
                res_status_r <= ST_DISPATCH;
                res_slot_r   <= hnd_r[KIND_CMD][SW-1:0];
                res_kind_r   <= KIND_CMD;
                state_r      <= S_IDREAD;
              end else if (run) begin
                cnt_r        <= run_idx;
                res_status_r <= ST_DONE;
                res_slot_r   <= run_idx;
                state_r      <= S_IDREAD;
              end else begin
                res_status_r <= ST_DONE;
                res_slot_r   <= '0;
                res_id_r     <= '0;
                state_r      <= S_OUT;
              end
            end
            default: state_r <= S_SCHED;
          endcase
        end
        S_RMW: begin
          if ((cmd_r == CMD_FINISH) && ent.is_hnd) begin
            running_r <= RW'(saved_r);
            state_r   <= S_SCHED;
          end else if (cmd_r == CMD_FINISH) begin
            used_r[cnt_r] <= 1'b0;
            sweep_id_r    <= ent.id;
            kill_r        <= 1'b0;
            found_r       <= 1'b0;
            cnt_r         <= '0;
            state_r       <= S_SWEEP;
          end else begin
            state_r <= S_SCHED;
          end
        end
        S_SWEEP: begin
          // dependency clear, and for kill the lowest used slot with the id
          if (kill_hit) begin
            used_r[cnt_r] <= 1'b0;
            found_r       <= 1'b1;
            for (int k = 0; k < NUM_KINDS; k++) begin
              if (hnd_r[k] == RW'(cnt_r)) begin
                hnd_r[k] <= NONE;
              end
            end
          end
          if (cnt_r == LAST) begin
            state_r <= S_SCHED;
          end else begin
            cnt_r <= SW'(cnt_r + 1'b1);
          end
        end
        S_SCHED: begin
          if (evt.hit) begin
            saved_r      <= run ? run_idx : '0;
            running_r    <= hnd_r[evt.kind];
            cnt_r        <= hnd_r[evt.kind][SW-1:0];
            res_status_r <= ST_DISPATCH;
            res_slot_r   <= hnd_r[evt.kind][SW-1:0];
            res_kind_r   <= evt.kind;
            res_val_r    <= evt.value;
            state_r      <= S_IDREAD;
          end else begin
            cnt_r   <= scan_start;
            steps_r <= '0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_ok) begin
            running_r    <= RW'(cnt_r);
            res_status_r <= ST_CHOSEN;
            res_slot_r   <= cnt_r;
            res_id_r     <= ent.id;
            state_r      <= S_OUT;
          end else if (steps_r == LAST) begin
            running_r    <= NONE;
            res_status_r <= ST_NONE;
            res_slot_r   <= '0;
            res_id_r     <= '0;
            state_r      <= S_OUT;
          end else begin
            cnt_r   <= nxt_slot(cnt_r);
            steps_r <= SW'(steps_r + 1'b1);
          end
        end
        S_IDREAD: begin
          res_id_r <= ent.id;
          state_r  <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_slot_r   <= SLOT_OUT_W'(res_slot_r);
            out_id_r     <= res_id_r;
            out_kind_r   <= res_kind_r;
            out_val_r    <= res_val_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.slot        = out_slot_r;
  assign out_ch.run_id      = out_id_r;
  assign out_ch.event_kind  = out_kind_r;
  assign out_ch.event_value = out_val_r;

  // checks on the sequencer
  `RRTS_ASSERT_ALWAYS(a_running_range, running_r <= NONE, "running slot out of range")
  `RRTS_ASSERT_ALWAYS(a_no_port_clash, !(wr_en && rd_en && (wr_addr == rd_addr)),
                      "table read and write collide")
  `RRTS_ASSERT_IMPLY(a_out_from_fsm, $rose(out_valid_r), $past(state_r == S_OUT),
                     "result loaded outside output state")
  `RRTS_ASSERT_IMPLY(a_dispatch_runs, (state_r == S_OUT) && (res_status_r == ST_DISPATCH),
                     running_r == RW'(res_slot_r), "dispatched handler not running")

endmodule
